>>> rtl/sgf_pkg.sv
// Package: shared constants, types and the front-to-back item record.
`timescale 1ns / 1ps
`default_nettype none
package sgf_pkg;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 4096;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int CfgW      = 13;
   localparam logic signed [10:0] GradLimit = 11'sd1020;
   localparam logic [10:0] MagLimit  = 11'd1442;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   // One classified window handed from the front part to the back part.
   typedef struct packed {
      logic signed [10:0] gx;
      logic signed [10:0] gy;
      logic               done;
      logic               first;
   } item_type;

   typedef enum logic [1:0] {
      SQ_IDLE = 2'd0,
      SQ_RUN  = 2'd1,
      SQ_OUT  = 2'd2
   } sqrt_state_type;
endpackage
`default_nettype wire

>>> rtl/sgf_front.sv
// Front part: line stores, window, counters and Sobel sums.
`timescale 1ns / 1ps
`default_nettype none
module sgf_front import sgf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 restart,
   input  wire logic [ColW:0]        width,
   input  wire logic [RowW:0]        height,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_pixel,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output item_type                  out_item
);
   logic [7:0] upper_mem [MaxWidth];
   logic [7:0] middle_mem [MaxWidth];
   logic [7:0] win_ff [3][3];
   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic first_ff;
   // stage between the store read and the sum
   logic            s1_valid_ff;
   logic            s1_emit_ff, s1_done_ff, s1_first_ff;
   logic [7:0]      s1_px_ff;
   logic            out_valid_ff;
   item_type        out_item_ff;
   logic [7:0]      top_ff, mid_ff;
   logic [ColW-1:0] col_hold_ff;
   logic            take, advance;
   logic signed [10:0] gx_in, gy_in;
   logic [ColW:0]   col_next;
   logic            last_col, last_row;

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   // the single stage may only advance when the output slot frees
   assign advance  = !out_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff && advance;
   assign take     = in_valid && in_ready;
   assign last_col = ({1'b0, col_ff} == width - 1'b1);
   assign last_row = ({1'b0, row_ff} == height - 1'b1);
   assign col_next = {1'b0, col_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (take) begin
         top_ff <= upper_mem[col_ff];
         mid_ff <= middle_mem[col_ff];
         s1_px_ff <= in_pixel;
      end
      if (s1_valid_ff) begin
         upper_mem[col_hold_ff] <= mid_ff;
         middle_mem[col_hold_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) col_hold_ff <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         first_ff <= 1'b1;
      end else if (take) begin
         if (row_ff >= 2 && col_ff >= 2) first_ff <= 1'b0;
         if (last_col) begin
            col_ff <= '0;
            if (last_row) begin
               row_ff <= '0;
               first_ff <= 1'b1;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end else begin
            col_ff <= col_next[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
      end
      if (take) begin
         s1_emit_ff  <= (row_ff >= 2) && (col_ff >= 2);
         s1_done_ff  <= last_row && last_col;
         s1_first_ff <= first_ff;
      end
   end

   // window shifts when the read data arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) win_ff[k][j] <= '0;
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= top_ff;
         win_ff[1][2] <= mid_ff;
         win_ff[2][2] <= s1_px_ff;
      end
   end

   // sums over the new window (old columns 1,2 plus new column)
   always_comb begin
      logic signed [11:0] l, m, rr, t, b;
      l  = 12'(win_ff[0][1]) + 12'({win_ff[1][1], 1'b0}) + 12'(win_ff[2][1]);
      rr = 12'(top_ff) + 12'({mid_ff, 1'b0}) + 12'(s1_px_ff);
      t  = 12'(win_ff[0][1]) + 12'({win_ff[0][2], 1'b0}) + 12'(top_ff);
      b  = 12'(win_ff[2][1]) + 12'({win_ff[2][2], 1'b0}) + 12'(s1_px_ff);
      m  = rr - l;
      gx_in = m[10:0];
      m  = b - t;
      gy_in = m[10:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
      if (advance && s1_valid_ff) begin
         out_item_ff.gx    <= gx_in;
         out_item_ff.gy    <= gy_in;
         out_item_ff.done  <= s1_done_ff;
         out_item_ff.first <= s1_first_ff;
      end
   end
endmodule
`default_nettype wire

>>> rtl/sgf_queue.sv
// Short queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module sgf_queue import sgf_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);
   item_type   slot_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 3'd4);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_item  = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) slot_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

>>> rtl/sgf_back.sv
// Back part: serial square root, frame extremes and the result register.
`timescale 1ns / 1ps
`default_nettype none
module sgf_back import sgf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire item_type           in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic signed [10:0]      grad_x,
   output logic signed [10:0]      grad_y,
   output logic [10:0]             magnitude,
   output logic                    frame_done,
   output logic signed [10:0]      gx_low,
   output logic signed [10:0]      gx_high,
   output logic signed [10:0]      gy_low,
   output logic signed [10:0]      gy_high,
   output logic [10:0]             mag_low,
   output logic [10:0]             mag_high
);
   sqrt_state_type state_ff, state_in;
   item_type   item_ff;
   logic [10:0] root_ff;
   logic [3:0]  step_ff;
   logic signed [10:0] gxl_ff, gxh_ff, gyl_ff, gyh_ff;
   logic [10:0] ml_ff, mh_ff;
   logic        ov_ff;
   logic signed [10:0] ogx_ff, ogy_ff, ogxl_ff, ogxh_ff, ogyl_ff, ogyh_ff;
   logic [10:0] omag_ff, oml_ff, omh_ff;
   logic        odone_ff;
   logic [20:0] sq_in;
   logic signed [10:0] bxl, bxh, byl, byh;
   logic [10:0] bml, bmh;
   logic        finish;

   always_comb begin
      logic signed [21:0] a, b;
      a = in_item.gx * in_item.gx;
      b = in_item.gy * in_item.gy;
      sq_in = 21'(a) + 21'(b);
   end

   // one result bit per cycle, restoring method
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: if (in_valid) state_in = SQ_RUN;
         SQ_RUN:  if (step_ff == 4'd10) state_in = SQ_OUT;
         SQ_OUT:  if (!ov_ff || out_ready) state_in = SQ_IDLE;
         default: state_in = SQ_IDLE;
      endcase
   end

   always_comb begin
      in_ready = (state_ff == SQ_IDLE);
      finish   = (state_ff == SQ_OUT) && (!ov_ff || out_ready);
   end

   logic [21:0] radicand_ff;
   logic [22:0] acc_ff;
   always_ff @(posedge clock) begin
      if (reset) state_ff <= SQ_IDLE;
      else state_ff <= state_in;
      if (state_ff == SQ_IDLE && in_valid) begin
         item_ff <= in_item;
         radicand_ff <= {1'b0, sq_in};
         acc_ff <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == SQ_RUN) begin
         logic [22:0] a2, t;
         a2 = {acc_ff[20:0], radicand_ff[21:20]};
         t  = {10'b0, root_ff, 2'b01};
         if (a2 >= t) begin
            acc_ff  <= a2 - t;
            root_ff <= {root_ff[9:0], 1'b1};
         end else begin
            acc_ff  <= a2;
            root_ff <= {root_ff[9:0], 1'b0};
         end
         radicand_ff <= {radicand_ff[19:0], 2'b00};
         step_ff <= step_ff + 1'b1;
      end
   end

   // extremes including the current item; a frame's first item reloads them
   always_comb begin
      bxl = item_ff.first ? GradLimit : gxl_ff;
      bxh = item_ff.first ? -GradLimit : gxh_ff;
      byl = item_ff.first ? GradLimit : gyl_ff;
      byh = item_ff.first ? -GradLimit : gyh_ff;
      bml = item_ff.first ? MagLimit : ml_ff;
      bmh = item_ff.first ? 11'd0 : mh_ff;
      if (item_ff.gx < bxl) bxl = item_ff.gx;
      if (item_ff.gx > bxh) bxh = item_ff.gx;
      if (item_ff.gy < byl) byl = item_ff.gy;
      if (item_ff.gy > byh) byh = item_ff.gy;
      if (root_ff < bml) bml = root_ff;
      if (root_ff > bmh) bmh = root_ff;
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         gxl_ff <= bxl; gxh_ff <= bxh; gyl_ff <= byl; gyh_ff <= byh;
         ml_ff <= bml;  mh_ff <= bmh;
         ogx_ff <= item_ff.gx;
         ogy_ff <= item_ff.gy;
         omag_ff <= root_ff;
         odone_ff <= item_ff.done;
         ogxl_ff <= item_ff.done ? bxl : 11'sd0;
         ogxh_ff <= item_ff.done ? bxh : 11'sd0;
         ogyl_ff <= item_ff.done ? byl : 11'sd0;
         ogyh_ff <= item_ff.done ? byh : 11'sd0;
         oml_ff  <= item_ff.done ? bml : 11'd0;
         omh_ff  <= item_ff.done ? bmh : 11'd0;
      end
      if (reset) ov_ff <= 1'b0;
      else if (finish) ov_ff <= 1'b1;
      else if (out_ready) ov_ff <= 1'b0;
   end

   assign out_valid = ov_ff;
   assign grad_x = ogx_ff;
   assign grad_y = ogy_ff;
   assign magnitude = omag_ff;
   assign frame_done = odone_ff;
   assign gx_low = ogxl_ff;
   assign gx_high = ogxh_ff;
   assign gy_low = ogyl_ff;
   assign gy_high = ogyh_ff;
   assign mag_low = oml_ff;
   assign mag_high = omh_ff;
endmodule
`default_nettype wire

>>> rtl/sobel_gradient_filter_3x3_top.sv
// Top level of the streaming 3x3 Sobel gradient filter.
// Pixels enter on the req_ channel in raster order, one transfer per pixel;
// the block holds the two previous rows in on-chip line stores and slides a
// 3x3 window. Every pixel at row 2 or later and column 2 or later produces
// one rsp_ transfer with the horizontal and vertical Sobel sums and the
// integer square root of their squared sum. The last window of a frame
// carries frame_done and the frame's minimum and maximum of all three.
// The front part takes a new pixel only after the last one has passed its
// stage (store read, then sum), and feeds a four-entry queue. The back part
// computes the root one bit per cycle and takes no new item until the last
// result has been registered.
// Pixels outside the valid window pass through the front part only.
// Reset is synchronous: counters, window and handshakes clear; the extreme
// registers and the line stores keep whatever they hold. A csr_ write
// restarts the frame and is to be made only while the block is idle; the
// block itself does not enforce this. When the receiver stalls, the result
// holds and the queue fills, after which req_ready falls.
`timescale 1ns / 1ps
`default_nettype none
module sobel_gradient_filter_3x3_top import sgf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [CfgW-1:0]   csr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_pixel,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [10:0]     rsp_grad_x,
   output logic signed [10:0]     rsp_grad_y,
   output logic [10:0]            rsp_magnitude,
   output logic                   rsp_frame_done,
   output logic signed [10:0]     rsp_grad_x_low,
   output logic signed [10:0]     rsp_grad_x_high,
   output logic signed [10:0]     rsp_grad_y_low,
   output logic signed [10:0]     rsp_grad_y_high,
   output logic [10:0]            rsp_mag_low,
   output logic [10:0]            rsp_mag_high
);
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [ColW:0] width_use;
   logic [RowW:0] height_use;
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   item_type fq_item, qb_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_data[10:0];
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp the registers to the supported frame sizes.
   always_comb begin
      if (width_ff < 11'd3) width_use = (ColW+1)'(3);
      else if (width_ff > 11'(MaxWidth)) width_use = (ColW+1)'(MaxWidth);
      else width_use = width_ff[ColW:0];
      if (height_ff < 13'd3) height_use = (RowW+1)'(3);
      else if (height_ff > 13'(MaxHeight)) height_use = (RowW+1)'(MaxHeight);
      else height_use = height_ff[RowW:0];
   end

   sgf_front u_front (
      .clock, .reset, .restart(csr_write), .width(width_use), .height(height_use),
      .in_valid(req_valid), .in_ready(req_ready), .in_pixel(req_pixel),
      .out_valid(fq_valid), .out_ready(fq_ready), .out_item(fq_item)
   );

   sgf_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
   );

   sgf_back u_back (
      .clock, .reset, .in_valid(qb_valid), .in_ready(qb_ready), .in_item(qb_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .grad_x(rsp_grad_x), .grad_y(rsp_grad_y), .magnitude(rsp_magnitude),
      .frame_done(rsp_frame_done), .gx_low(rsp_grad_x_low), .gx_high(rsp_grad_x_high),
      .gy_low(rsp_grad_y_low), .gy_high(rsp_grad_y_high),
      .mag_low(rsp_mag_low), .mag_high(rsp_mag_high)
   );
endmodule
`default_nettype wire

>>> rtl/sgf_checker.sv
// Port-level checker for the Sobel filter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module sgf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [10:0] rsp_grad_x,
   input wire logic [10:0]       rsp_magnitude,
   input wire logic              rsp_frame_done,
   input wire logic signed [10:0] rsp_grad_x_low,
   input wire logic signed [10:0] rsp_grad_x_high,
   input wire logic [10:0]       rsp_mag_low,
   input wire logic [10:0]       rsp_mag_high
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magnitude))
      else $error("result dropped while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_mag_low == 11'd0 && rsp_mag_high == 11'd0)
      else $error("extremes not zero");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_grad_x_low <= rsp_grad_x
         && rsp_grad_x <= rsp_grad_x_high && rsp_mag_low <= rsp_magnitude
         && rsp_magnitude <= rsp_mag_high)
      else $error("extremes do not bracket last result");
endmodule

bind sobel_gradient_filter_3x3_top sgf_checker u_checker (.*);
`default_nettype wire
